// ----- rtl/core/cmp_pkg.sv -----
package cmp_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int RATIO_W  = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIV_W    = 24;
  localparam int DIVD_W   = 2 * DIV_W;
  localparam int ACC_W    = 41;

  // Fixed-point constants.
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 24'd8388608;
  localparam logic [SAMPLE_W-1:0] ENV_FLOOR  = 24'd84;
  localparam logic [RATIO_W-1:0]  RATIO_ONE  = 16'd256;
  localparam logic [COEF_W:0]     COEF_ONE   = 17'd65536;
  localparam logic [ACC_W:0]      ENV_ROUND  = 42'd32768;
  localparam logic [PROD_W-1:0]   GAIN_ROUND = 50'd4194304;
  localparam logic [SAMPLE_W-1:0] SAT_MAX    = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN    = 24'h800000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ENV,
    ST_MUL_MAG,
    ST_ENV,
    ST_CHECK,
    ST_DIV_EXC,
    ST_DIV_GAIN,
    ST_MUL_GAIN,
    ST_DONE
  } cmp_state_t;

endpackage

// ----- rtl/core/cmp_if.sv -----
// Input sample channel.
interface cmp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cmp_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Result sample channel.
interface cmp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cmp_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/audio_compressor.sv -----
// An accepted word passes through two multiplies, the envelope update and a threshold check;
// at or below the threshold it goes to the output register, above it two 24-step divisions
// on the shared divider and the gain multiply come first. One word is in work at a time, but
// a new word is taken while a result waits for ready.
// Reset (rst_n, synchronous, active low) clears the envelope, loads the register
// defaults and empties the output register.
module audio_compressor (
  input  logic                             clk,
  input  logic                             rst_n,
  cmp_in_if.sink                           in_if,
  cmp_out_if.source                        out_if,
  input  logic                             cfg_we,
  input  logic [cmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int SW = cmp_pkg::SAMPLE_W;
  localparam int CW = cmp_pkg::COEF_W;

  cmp_pkg::cmp_state_t state_r, state_nxt;

  // Configuration registers.
  logic [SW-1:0]                   thr_r;
  logic [cmp_pkg::RATIO_W-1:0]     ratio_r;
  logic [CW-1:0]                   atk_r;
  logic [CW-1:0]                   rel_r;

  // Working registers.
  logic [SW-1:0]                   env_r, env_nxt;
  logic signed [SW-1:0]            smp_r, smp_nxt;
  logic [SW-1:0]                   mag_r, mag_nxt;
  logic [CW-1:0]                   coef_r, coef_nxt;
  logic [cmp_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [SW-1:0]            res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]            out_data_r, out_data_nxt;

  // Shared unit connections.
  logic signed [cmp_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [cmp_pkg::PROD_W-1:0] mul_p;
  logic                              div_start, div_done;
  logic [cmp_pkg::DIVD_W-1:0]        div_dividend;
  logic [cmp_pkg::DIV_W-1:0]         div_divisor;
  logic [cmp_pkg::DIV_W-1:0]         div_q;

  // Helper values.
  logic                              in_accept;
  logic                              out_load;
  logic [SW-1:0]                     in_mag;
  logic [cmp_pkg::ACC_W:0]           env_sum;
  logic [cmp_pkg::RATIO_W-1:0]       ratio_eff;
  logic [SW-1:0]                     env_excess;
  logic [SW-1:0]                     compressed;
  logic [SW-1:0]                     gain_divisor;
  logic [cmp_pkg::PROD_W-1:0]        gain_biased;
  logic [SW+2:0]                     gain_scaled;
  logic                              gain_ovf;
  logic [CW:0]                       coef_inv;

  assign in_accept = in_if.valid && in_if.ready;
  assign out_load  = (state_r == cmp_pkg::ST_DONE) && (!out_valid_r || out_if.ready);

  assign in_mag = in_if.sample_in[SW-1] ? (~in_if.sample_in + 1'b1) : in_if.sample_in;
  assign coef_inv = cmp_pkg::COEF_ONE - {1'b0, coef_r};

  // Envelope update: products summed with round half up, then scaled by 2^-16.
  assign env_sum = {1'b0, acc_r} + {1'b0, mul_p[cmp_pkg::ACC_W-1:0]} + cmp_pkg::ENV_ROUND;

  assign ratio_eff    = (ratio_r < cmp_pkg::RATIO_ONE) ? cmp_pkg::RATIO_ONE : ratio_r;
  assign env_excess   = env_r - thr_r;
  assign compressed   = thr_r + div_q;
  assign gain_divisor = (env_r < cmp_pkg::ENV_FLOOR) ? cmp_pkg::ENV_FLOOR : env_r;

  // Gain product rounded to Q1.23; overflow when the top bits disagree with the sign.
  assign gain_biased = mul_p + cmp_pkg::GAIN_ROUND;
  assign gain_scaled = gain_biased[cmp_pkg::PROD_W-1:23];
  assign gain_ovf    = (gain_scaled[SW+2:SW-1] != {4{gain_scaled[SW+2]}});

  cmp_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (mul_p)
  );

  cmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cmp_pkg::ST_IDLE:     if (in_accept) state_nxt = cmp_pkg::ST_MUL_ENV;
      cmp_pkg::ST_MUL_ENV:  state_nxt = cmp_pkg::ST_MUL_MAG;
      cmp_pkg::ST_MUL_MAG:  state_nxt = cmp_pkg::ST_ENV;
      cmp_pkg::ST_ENV:      state_nxt = cmp_pkg::ST_CHECK;
      cmp_pkg::ST_CHECK: begin
        state_nxt = (env_r > thr_r) ? cmp_pkg::ST_DIV_EXC : cmp_pkg::ST_DONE;
      end
      cmp_pkg::ST_DIV_EXC:  if (div_done) state_nxt = cmp_pkg::ST_DIV_GAIN;
      cmp_pkg::ST_DIV_GAIN: if (div_done) state_nxt = cmp_pkg::ST_MUL_GAIN;
      cmp_pkg::ST_MUL_GAIN: state_nxt = cmp_pkg::ST_DONE;
      cmp_pkg::ST_DONE:     if (out_load) state_nxt = cmp_pkg::ST_IDLE;
      default:              state_nxt = cmp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: operand selection and working register updates.
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    env_nxt      = env_r;
    smp_nxt      = smp_r;
    mag_nxt      = mag_r;
    coef_nxt     = coef_r;
    acc_nxt      = acc_r;
    res_nxt      = res_r;
    unique case (state_r)
      cmp_pkg::ST_IDLE: begin
        if (in_accept) begin
          smp_nxt  = in_if.sample_in;
          mag_nxt  = in_mag;
          coef_nxt = (in_mag > env_r) ? atk_r : rel_r;
        end
      end
      cmp_pkg::ST_MUL_ENV: begin
        mul_a = {{(cmp_pkg::MUL_W-CW){1'b0}}, coef_r};
        mul_b = {1'b0, env_r};
      end
      cmp_pkg::ST_MUL_MAG: begin
        mul_a   = {{(cmp_pkg::MUL_W-CW-1){1'b0}}, coef_inv};
        mul_b   = {1'b0, mag_r};
        acc_nxt = mul_p[cmp_pkg::ACC_W-1:0];
      end
      cmp_pkg::ST_ENV: begin
        env_nxt = env_sum[SW+15:16];
      end
      cmp_pkg::ST_CHECK: begin
        res_nxt = smp_r;
        if (env_r > thr_r) begin
          div_start    = 1'b1;
          div_dividend = {16'd0, env_excess, 8'd0};
          div_divisor  = {8'd0, ratio_eff};
        end
      end
      cmp_pkg::ST_DIV_EXC: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {1'b0, compressed, 23'd0};
          div_divisor  = gain_divisor;
        end
      end
      cmp_pkg::ST_DIV_GAIN: begin
        mul_a = {smp_r[SW-1], smp_r};
        mul_b = {1'b0, div_q};
      end
      cmp_pkg::ST_MUL_GAIN: begin
        if (gain_ovf) begin
          res_nxt = gain_scaled[SW+2] ? cmp_pkg::SAT_MIN : cmp_pkg::SAT_MAX;
        end else begin
          res_nxt = gain_scaled[SW-1:0];
        end
      end
      cmp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded from the result, emptied when the word is taken.
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (out_load) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmp_pkg::ST_IDLE;
      env_r       <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= cmp_pkg::FULL_SCALE;
      ratio_r     <= cmp_pkg::RATIO_ONE;
      atk_r       <= '0;
      rel_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          cmp_pkg::CFG_THRESHOLD: thr_r   <= cfg_data;
          cmp_pkg::CFG_RATIO:     ratio_r <= cfg_data[cmp_pkg::RATIO_W-1:0];
          cmp_pkg::CFG_ATTACK:    atk_r   <= cfg_data[CW-1:0];
          cmp_pkg::CFG_RELEASE:   rel_r   <= cfg_data[CW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    mag_r      <= mag_nxt;
    coef_r     <= coef_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_if.ready       = (state_r == cmp_pkg::ST_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_data_r;

endmodule

// ----- rtl/core/cmp_mul.sv -----
// Shared signed multiplier with a registered product.
module cmp_mul (
  input  logic                              clk,
  input  logic signed [cmp_pkg::MUL_W-1:0]  mul_a,
  input  logic signed [cmp_pkg::MUL_W-1:0]  mul_b,
  output logic signed [cmp_pkg::PROD_W-1:0] prod
);

  logic signed [cmp_pkg::PROD_W-1:0] prod_r;
  logic signed [cmp_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;
  assign prod     = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/core/cmp_div.sv -----
// Restoring divider, one quotient bit per cycle.
// The upper half of the dividend must be below the divisor.
module cmp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [cmp_pkg::DIVD_W-1:0]        dividend,
  input  logic [cmp_pkg::DIV_W-1:0]         divisor,
  output logic                              done,
  output logic [cmp_pkg::DIV_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(cmp_pkg::DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(cmp_pkg::DIV_W - 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [cmp_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [cmp_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [cmp_pkg::DIV_W-1:0] dsr_r, dsr_nxt;
  logic [cmp_pkg::DIV_W:0]   trial;
  logic [cmp_pkg::DIV_W:0]   diff;
  logic                      fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_r, quo_r[cmp_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  // Step control and remainder update.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[cmp_pkg::DIV_W-1:0] : trial[cmp_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[cmp_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = dividend[cmp_pkg::DIVD_W-1:cmp_pkg::DIV_W];
      quo_nxt  = dividend[cmp_pkg::DIV_W-1:0];
      dsr_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/cmp_chk.sv -----
// Port-level checks on the compressor.
module cmp_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [cmp_pkg::SAMPLE_W-1:0]     out_sample
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_sample))
    else $error("result word changed while stalled");

  // Only one word is in work: ready drops right after an accepted word.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in work");

  // A new result only appears at the end of a word's work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word in work");

endmodule

bind audio_compressor cmp_chk u_cmp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_sample (out_if.sample_out)
);

// ----- sim/audio_compressor_test.sv -----
module audio_compressor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW              = cmp_pkg::SAMPLE_W;
  localparam int CW              = cmp_pkg::CFG_W;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 205;
  localparam int HOLD_CYCLES     = 400;
  localparam int MAX_REPORTS     = 10;
  localparam longint OUT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (SW - 1));
  localparam logic signed [SW-1:0] PEAK_POS = cmp_pkg::SAT_MAX;
  localparam logic signed [SW-1:0] PEAK_NEG = cmp_pkg::SAT_MIN;

  // One row of the directed sequence: either a register write or a sample word.
  typedef struct {
    bit                                is_cfg;
    logic [cmp_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [CW-1:0]                     reg_value;
    logic signed [SW-1:0]              sample;
    bit                                typed;
    logic signed [SW-1:0]              want;
  } plan_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cmp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]                 cfg_data;

  cmp_in_if  in_ch ();
  cmp_out_if out_ch ();

  // Local copy of the compressor registers and envelope.
  logic [SW-1:0]               thr_q;
  logic [cmp_pkg::RATIO_W-1:0] ratio_q;
  logic [cmp_pkg::COEF_W-1:0]  attack_q;
  logic [cmp_pkg::COEF_W-1:0]  release_q;
  logic [SW-1:0]               env_q;

  logic signed [SW-1:0] expected_samples[$];
  plan_row_t            plan[$];

  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  bit seg_loud  = 1'b0;
  int seg_left  = 0;

  int mismatches      = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int reduced_cnt     = 0;
  int cfg_writes      = 0;

  audio_compressor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Predict one output word and advance the envelope.
  function automatic logic signed [SW-1:0] compress_sample(
      input logic signed [SW-1:0] x);
    longint s, mag, env, coef, ratio, excess, squeezed, divisor, gain, res;
    s = x;
    mag = (s < 0) ? -s : s;
    env = env_q;
    coef = (mag > env) ? longint'(attack_q) : longint'(release_q);
    // One-pole smoothing in Q0.16, rounded half up.
    env = (coef * env + (longint'(cmp_pkg::COEF_ONE) - coef) * mag +
           longint'(cmp_pkg::ENV_ROUND)) >>> 16;
    env_q = env[SW-1:0];
    res = s;
    if (env > longint'(thr_q)) begin
      // Above threshold: scale the overshoot by the ratio and turn it into a gain.
      reduced_cnt++;
      ratio = (ratio_q < cmp_pkg::RATIO_ONE) ? longint'(cmp_pkg::RATIO_ONE) :
              longint'(ratio_q);
      excess = ((env - longint'(thr_q)) * 256) / ratio;
      squeezed = longint'(thr_q) + excess;
      divisor = (env < longint'(cmp_pkg::ENV_FLOOR)) ? longint'(cmp_pkg::ENV_FLOOR) : env;
      gain = (squeezed <<< (SW - 1)) / divisor;
      res = (s * gain + longint'(cmp_pkg::GAIN_ROUND)) >>> (SW - 1);
      if (res > OUT_HI) begin
        res = OUT_HI;
      end else if (res < OUT_LO) begin
        res = OUT_LO;
      end
    end
    return res[SW-1:0];
  endfunction

  function automatic plan_row_t cfg_row(input logic [cmp_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [CW-1:0] data);
    return '{is_cfg: 1'b1, reg_idx: idx, reg_value: data, sample: '0, typed: 1'b0,
             want: '0};
  endfunction

  function automatic plan_row_t word_row(input logic signed [SW-1:0] x);
    return '{is_cfg: 1'b0, reg_idx: cmp_pkg::CFG_THRESHOLD, reg_value: '0, sample: x,
             typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t known_row(input logic signed [SW-1:0] x,
                                          input logic signed [SW-1:0] y);
    return '{is_cfg: 1'b0, reg_idx: cmp_pkg::CFG_THRESHOLD, reg_value: '0, sample: x,
             typed: 1'b1, want: y};
  endfunction

  // Mix of full-range noise, extremes, tiny values and loud/quiet passages.
  function automatic logic signed [SW-1:0] next_sample();
    int pick;
    int m;
    logic signed [SW-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      v = SW'($urandom());
    end else if (pick < 30) begin
      case ($urandom_range(0, 4))
        0:       v = PEAK_POS;
        1:       v = PEAK_NEG;
        2:       v = '0;
        3:       v = 24'sd1;
        default: v = -24'sd1;
      endcase
    end else if (pick < 45) begin
      m = $urandom_range(0, 200);
      v = SW'($urandom_range(0, 1) ? -m : m);
    end else begin
      // Alternate loud and quiet stretches so attack and release both get exercised.
      if (seg_left == 0) begin
        seg_loud = !seg_loud;
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      m = seg_loud ? $urandom_range(3000000, 8388607) : $urandom_range(0, 100000);
      v = SW'($urandom_range(0, 1) ? -m : m);
    end
    return v;
  endfunction

  function automatic logic [CW-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CW'(16'hFFFF);
      2:       return CW'($urandom_range(0, 65535));
      default: return CW'($urandom_range(50000, 65535));
    endcase
  endfunction

  task automatic report_bad(input string what, input logic signed [SW-1:0] want,
                            input logic signed [SW-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offer one sample word, after an optional idle burst, and record its prediction.
  task automatic send_word(input logic signed [SW-1:0] x, input bit typed,
                           input logic signed [SW-1:0] known);
    logic signed [SW-1:0] predicted;
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = compress_sample(x);
    expected_samples.push_back(typed ? known : predicted);
    words_sent++;
  endtask

  // Register writes happen only once every pending word has come out.
  task automatic cfg_write(input logic [cmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] data);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cmp_pkg::CFG_THRESHOLD: thr_q     = data[SW-1:0];
      cmp_pkg::CFG_RATIO:     ratio_q   = data[cmp_pkg::RATIO_W-1:0];
      cmp_pkg::CFG_ATTACK:    attack_q  = data[cmp_pkg::COEF_W-1:0];
      cmp_pkg::CFG_RELEASE:   release_q = data[cmp_pkg::COEF_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Output side: random stalls, one long hold-off on request, none in the calm phase.
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk) begin : check_output
    logic signed [SW-1:0] want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report_bad("output word with nothing pending", 'x, out_ch.sample_out);
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (out_ch.sample_out !== want) begin
          report_bad("sample_out mismatch", want, out_ch.sample_out);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d output words still pending.", expected_samples.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [CW-1:0] thr_v;
    logic [CW-1:0] ratio_v;
    logic [CW-1:0] atk_v;
    logic [CW-1:0] rel_v;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = cmp_pkg::CFG_THRESHOLD;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    thr_q     = cmp_pkg::FULL_SCALE;
    ratio_q   = cmp_pkg::RATIO_ONE;
    attack_q  = '0;
    release_q = '0;
    env_q     = '0;

    // Reset defaults pass every sample unchanged, the most negative one included.
    plan.push_back(known_row('0, '0));
    plan.push_back(known_row(PEAK_POS, PEAK_POS));
    plan.push_back(known_row(PEAK_NEG, PEAK_NEG));
    plan.push_back(known_row(24'sd1, 24'sd1));
    plan.push_back(known_row(-24'sd1, -24'sd1));
    // Zero threshold with a ratio below one: unity gain except near the divisor floor.
    plan.push_back(cfg_row(cmp_pkg::CFG_THRESHOLD, '0));
    plan.push_back(cfg_row(cmp_pkg::CFG_RATIO, '0));
    plan.push_back(word_row(24'sd1));
    plan.push_back(word_row(24'sd83));
    plan.push_back(word_row(24'sd84));
    plan.push_back(known_row(PEAK_POS, PEAK_POS));
    plan.push_back(known_row(PEAK_NEG, PEAK_NEG));
    plan.push_back(known_row('0, '0));
    // Half-scale threshold at the steepest ratio, around and on the knee.
    plan.push_back(cfg_row(cmp_pkg::CFG_THRESHOLD, 24'd4194304));
    plan.push_back(cfg_row(cmp_pkg::CFG_RATIO, 24'd65535));
    plan.push_back(word_row(PEAK_POS));
    plan.push_back(word_row(PEAK_NEG));
    plan.push_back(word_row(24'sd4194305));
    plan.push_back(word_row(24'sd4194304));
    plan.push_back(word_row(-24'sd5000000));
    // A threshold above full scale can never be crossed.
    plan.push_back(cfg_row(cmp_pkg::CFG_THRESHOLD, 24'hFFFFFF));
    plan.push_back(cfg_row(cmp_pkg::CFG_RATIO, 24'd512));
    plan.push_back(known_row(PEAK_NEG, PEAK_NEG));
    plan.push_back(known_row(PEAK_POS, PEAK_POS));
    // Slowest envelope in both directions.
    plan.push_back(cfg_row(cmp_pkg::CFG_THRESHOLD, '0));
    plan.push_back(cfg_row(cmp_pkg::CFG_ATTACK, 24'd65535));
    plan.push_back(cfg_row(cmp_pkg::CFG_RELEASE, 24'd65535));
    plan.push_back(word_row(PEAK_POS));
    plan.push_back(word_row(PEAK_NEG));
    plan.push_back(word_row('0));
    // Typical fast attack, slow release setting.
    plan.push_back(cfg_row(cmp_pkg::CFG_ATTACK, 24'd1000));
    plan.push_back(cfg_row(cmp_pkg::CFG_RELEASE, 24'd60000));
    plan.push_back(cfg_row(cmp_pkg::CFG_THRESHOLD, 24'd1000000));
    plan.push_back(cfg_row(cmp_pkg::CFG_RATIO, 24'd1024));
    plan.push_back(word_row(24'sd3000000));
    plan.push_back(word_row(-24'sd3000000));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        cfg_write(plan[i].reg_idx, plan[i].reg_value);
      end else begin
        send_word(plan[i].sample, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting; the last one runs without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p == RANDOM_PHASES - 1);
      case (p)
        0: begin
          thr_v = '0; ratio_v = '0; atk_v = '0; rel_v = '0;
        end
        1: begin
          thr_v = 24'd1000; ratio_v = 24'd65535; atk_v = 24'd65535; rel_v = 24'd65535;
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       thr_v = '0;
            1:       thr_v = cmp_pkg::FULL_SCALE;
            2:       thr_v = CW'($urandom_range(8388609, 16777215));
            default: thr_v = CW'($urandom_range(0, 6000000));
          endcase
          case ($urandom_range(0, 4))
            0:       ratio_v = CW'($urandom_range(0, 255));
            1:       ratio_v = 24'd65535;
            2:       ratio_v = CW'(cmp_pkg::RATIO_ONE);
            default: ratio_v = CW'($urandom_range(257, 4096));
          endcase
          atk_v = pick_coef();
          rel_v = pick_coef();
        end
      endcase
      cfg_write(cmp_pkg::CFG_THRESHOLD, thr_v);
      cfg_write(cmp_pkg::CFG_RATIO, ratio_v);
      cfg_write(cmp_pkg::CFG_ATTACK, atk_v);
      cfg_write(cmp_pkg::CFG_RELEASE, rel_v);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(next_sample(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d samples across %0d register writes; %0d output words checked.",
             words_sent, cfg_writes, results_checked);
    $display("%0d words went through gain reduction; one %0d-cycle output hold-off was applied.",
             reduced_cnt, HOLD_CYCLES);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cmp_pkg.sv
rtl/core/cmp_if.sv
rtl/core/cmp_mul.sv
rtl/core/cmp_div.sv
rtl/core/audio_compressor.sv
rtl/core/cmp_chk.sv
sim/audio_compressor_test.sv
